// File: hdl/bprq_pkg.sv
// Package: shared types and constants of the bitmap priority ready queue.
package bprq_pkg;

  localparam int KIND_W = 2;
  localparam int TASK_W = 6;
  localparam int PRIO_W = 5;
  localparam int STAT_W = 2;
  localparam int MASK_W = 32;

  localparam logic [KIND_W-1:0] KIND_ENQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REM = 2'd1;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_QUEUED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_TOP,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic top;
  } cmd_t;

endpackage

// File: hdl/bprq_ctrl.sv
// Controller: sequences one transaction through read, update, top lookup and output.
module bprq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output bprq_pkg::cmd_t cmd
);
  import bprq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        cmd.top   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_in_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("accept while result pending");
  a_load_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_READ) else $error("load not followed by read");
  a_top_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.top |=> out_tvalid) else $error("top lookup not followed by output");
`endif
endmodule

// File: hdl/bprq_dp.sv
// Datapath: link memories, level tables, bitmap and top-of-queue lookup.
module bprq_dp #(
  parameter int LEVELS    = 32,
  parameter int MAX_TASKS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bprq_pkg::cmd_t                cmd,
  input  logic [bprq_pkg::KIND_W-1:0]   kind,
  input  logic [bprq_pkg::TASK_W-1:0]   task_id,
  input  logic [bprq_pkg::PRIO_W-1:0]   priority_req,
  input  logic                          at_head,
  input  logic                          cfg_we,
  input  logic [bprq_pkg::TASK_W-1:0]   cfg_data,
  output logic [bprq_pkg::STAT_W-1:0]   status,
  output logic                          top_valid,
  output logic [bprq_pkg::TASK_W-1:0]   top_task,
  output logic [bprq_pkg::PRIO_W-1:0]   top_priority,
  output logic [bprq_pkg::MASK_W-1:0]   nonempty_mask
);
  import bprq_pkg::*;

  localparam int TI_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LI_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  logic [TASK_W-1:0] head_mem [LEVELS];
  logic [TASK_W-1:0] tail_mem [LEVELS];
  logic [TASK_W-1:0] next_mem [MAX_TASKS];
  logic [TASK_W-1:0] prev_mem [MAX_TASKS];
  logic [PRIO_W-1:0] lvl_mem  [MAX_TASKS];
  logic [MAX_TASKS-1:0] queued_r;
  logic [LEVELS-1:0]    bmp_r;
  logic [TASK_W-1:0]    idle_r;

  logic [KIND_W-1:0] kind_r;
  logic [TASK_W-1:0] tid_r;
  logic [PRIO_W-1:0] preq_r;
  logic              head_r;

  logic [TASK_W-1:0] nx_r, pv_r, hd_r, tl_r;
  logic [PRIO_W-1:0] tlvl_r;
  logic [LI_W-1:0]   elvl_r;
  logic [STAT_W-1:0] stat_r;

  logic              tid_ok;
  logic [TI_W-1:0]   ti;
  logic [LI_W-1:0]   elvl;
  logic [LI_W-1:0]   rlvl;
  logic [LI_W-1:0]   lvl_sel;
  logic              is_q;
  logic [LI_W-1:0]   first_lvl;
  logic              any_q;

  assign tid_ok = ({{(32-TASK_W){1'b0}}, tid_r} < 32'(MAX_TASKS));
  assign ti     = tid_r[TI_W-1:0];
  assign is_q   = tid_ok && queued_r[ti];
  assign rlvl   = tlvl_r[LI_W-1:0];

  always_comb begin
    if ({{(32-PRIO_W){1'b0}}, preq_r} >= 32'(LEVELS)) begin
      elvl = LI_W'(LEVELS - 1);
    end else begin
      elvl = preq_r[LI_W-1:0];
    end
  end

  assign lvl_sel = (kind_r == KIND_ENQ) ? elvl : rlvl;

  always_comb begin
    first_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (bmp_r[i]) begin
        first_lvl = LI_W'(i);
      end
    end
  end
  assign any_q = |bmp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= '0;
    end else if (cfg_we) begin
      idle_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      tid_r  <= task_id;
      preq_r <= priority_req;
      head_r <= at_head;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      nx_r   <= next_mem[ti];
      pv_r   <= prev_mem[ti];
      tlvl_r <= lvl_mem[ti];
      elvl_r <= elvl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hd_r <= head_mem[lvl_sel];
      tl_r <= tail_mem[lvl_sel];
    end
  end

  // exec cycle reads head/tail; top cycle commits the update
  logic [LI_W-1:0] ul;
  assign ul = (kind_r == KIND_ENQ) ? elvl_r : rlvl;

  always_ff @(posedge clk) begin
    if (cmd.top && kind_r == KIND_ENQ && tid_ok && !queued_r[ti]) begin
      lvl_mem[ti] <= PRIO_W'(ul);
      if (!bmp_r[ul]) begin
        head_mem[ul] <= tid_r;
        tail_mem[ul] <= tid_r;
      end else if (head_r) begin
        next_mem[ti] <= hd_r;
        prev_mem[hd_r[TI_W-1:0]] <= tid_r;
        head_mem[ul] <= tid_r;
      end else begin
        prev_mem[ti] <= tl_r;
        next_mem[tl_r[TI_W-1:0]] <= tid_r;
        tail_mem[ul] <= tid_r;
      end
    end else if (cmd.top && kind_r == KIND_REM && is_q) begin
      if (hd_r == tid_r && tl_r == tid_r) begin
      end else if (hd_r == tid_r) begin
        head_mem[ul] <= nx_r;
      end else if (tl_r == tid_r) begin
        tail_mem[ul] <= pv_r;
      end else begin
        next_mem[pv_r[TI_W-1:0]] <= nx_r;
        prev_mem[nx_r[TI_W-1:0]] <= pv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r <= '0;
      bmp_r    <= '0;
    end else if (cmd.top && kind_r == KIND_ENQ && tid_ok && !queued_r[ti]) begin
      queued_r[ti] <= 1'b1;
      bmp_r[ul]    <= 1'b1;
    end else if (cmd.top && kind_r == KIND_REM && is_q) begin
      queued_r[ti] <= 1'b0;
      if (hd_r == tid_r && tl_r == tid_r) begin
        bmp_r[ul] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.top) begin
      priority case (1'b1)
        kind_r == KIND_ENQ: stat_r <= !tid_ok ? ST_NOT_QUEUED :
                                      (queued_r[ti] ? ST_QUEUED : ST_OK);
        kind_r == KIND_REM: stat_r <= is_q ? ST_OK : ST_NOT_QUEUED;
        default:            stat_r <= ST_OK;
      endcase
    end
  end

  // top lookup reads committed state during the output cycle
  always_comb begin
    top_valid = any_q;
    if (any_q) begin
      top_task     = head_mem[first_lvl];
      top_priority = PRIO_W'(first_lvl);
    end else begin
      top_task     = idle_r;
      top_priority = '0;
    end
  end

  always_comb begin
    nonempty_mask = '0;
    for (int i = 0; i < LEVELS; i++) begin
      nonempty_mask[MASK_W-1-i] = bmp_r[i];
    end
  end

  assign status = stat_r;

`ifndef SYNTHESIS
  a_bad_id: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.top && !tid_ok && (kind_r == KIND_ENQ || kind_r == KIND_REM)
      |=> stat_r == ST_NOT_QUEUED) else $error("bad id not flagged");
  a_enq_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.top && kind_r == KIND_ENQ && tid_ok && !queued_r[ti]
      |=> queued_r[ti] && bmp_r[ul]) else $error("enqueue not recorded");
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    !(|bmp_r) |-> top_task == idle_r) else $error("idle task not shown");
`endif
endmodule

// File: hdl/bitmap_priority_ready_queue.sv
// Top level: bitmap multilevel priority ready queue.
// Usage:
//   in_*  channel carries one operation per transaction: enqueue, remove or query.
//   out_* channel returns one result per operation: status, top task and bitmap.
//   cfg_* channel writes the idle task id; write only while the block is idle.
// Timing:
//   An operation is taken in the idle state, then passes through the task
//   link read, the level head and tail read and the update write before
//   the result is offered.
//   One operation is in flight at a time, set by the read-modify-write of
//   the link memories; no new operation is taken until its result is accepted.
// Reset:
//   rst_n clears the bitmap, the queued flags and the idle task; link and
//   level tables are written before they are read and need no clearing.
// Stall:
//   A held result stays on out_tdata until out_tready; no new input is taken.
module bitmap_priority_ready_queue #(
  parameter int LEVELS    = 32,
  parameter int MAX_TASKS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // kind[1:0], task_id[7:2], priority_req[12:8], at_head[13]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], top_valid[2], top_task[8:3],
                                  // top_priority[13:9], nonempty_mask[45:14]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // idle_task[5:0]
);
  import bprq_pkg::*;

  cmd_t              cmd;
  logic [STAT_W-1:0] status;
  logic              top_valid;
  logic [TASK_W-1:0] top_task;
  logic [PRIO_W-1:0] top_priority;
  logic [MASK_W-1:0] nonempty_mask;

  assign cfg_ready = 1'b1;

  bprq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  bprq_dp #(
    .LEVELS    (LEVELS),
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .kind          (in_tdata[1:0]),
    .task_id       (in_tdata[7:2]),
    .priority_req  (in_tdata[12:8]),
    .at_head       (in_tdata[13]),
    .cfg_we        (cfg_valid),
    .cfg_data      (cfg_data[5:0]),
    .status        (status),
    .top_valid     (top_valid),
    .top_task      (top_task),
    .top_priority  (top_priority),
    .nonempty_mask (nonempty_mask)
  );

  assign out_tdata = {2'b00, nonempty_mask, top_priority, top_task, top_valid, status};
endmodule

// File: tb/tb_bitmap_priority_ready_queue.sv
// Testbench: ready queue operations checked against a behavioural queue predictor.
module tb_bitmap_priority_ready_queue;
  import bprq_pkg::*;

  localparam int NLEV = 32;
  localparam int NTASK = 64;
  localparam logic [KIND_W-1:0] KIND_QRY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ODD = 2'd3;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              top_valid;
    logic [TASK_W-1:0] top_task;
    logic [PRIO_W-1:0] top_prio;
    logic [MASK_W-1:0] mask;
  } sched_res_t;

  class sched_scoreboard;
    logic [TASK_W-1:0] head_q[NLEV][$];
    bit                queued[NTASK];
    logic [PRIO_W-1:0] lvl_of[NTASK];
    logic [TASK_W-1:0] idle_id;
    sched_res_t        pending[$];
    int                errors;
    int                checked;

    function new();
      idle_id = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void note_op(logic [KIND_W-1:0] k, logic [TASK_W-1:0] t,
                          logic [PRIO_W-1:0] p, logic h);
      sched_res_t r;
      int idx;
      r = '0;
      r.status = ST_OK;
      if (k == KIND_ENQ) begin
        if (queued[t]) r.status = ST_QUEUED;
        else begin
          if (h) head_q[p].push_front(t);
          else head_q[p].push_back(t);
          queued[t] = 1;
          lvl_of[t] = p;
        end
      end else if (k == KIND_REM) begin
        if (!queued[t]) r.status = ST_NOT_QUEUED;
        else begin
          idx = -1;
          for (int i = 0; i < head_q[lvl_of[t]].size(); i++)
            if (head_q[lvl_of[t]][i] == t) idx = i;
          head_q[lvl_of[t]].delete(idx);
          queued[t] = 0;
        end
      end
      r.top_task = idle_id;
      for (int l = NLEV - 1; l >= 0; l--) begin
        if (head_q[l].size() != 0) begin
          r.mask[31-l] = 1'b1;
          r.top_valid = 1'b1;
          r.top_task = head_q[l][0];
          r.top_prio = PRIO_W'(l);
        end
      end
      pending.push_back(r);
    endfunction

    function void check_res(sched_res_t a);
      sched_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++; end
      if (a.top_valid !== e.top_valid) begin
        $error("top_valid exp %0d got %0d", e.top_valid, a.top_valid); errors++; end
      if (a.top_task !== e.top_task) begin
        $error("top_task exp %0d got %0d", e.top_task, a.top_task); errors++; end
      if (a.top_prio !== e.top_prio) begin
        $error("top_priority exp %0d got %0d", e.top_prio, a.top_prio); errors++; end
      if (a.mask !== e.mask) begin
        $error("nonempty_mask exp %h got %h", e.mask, a.mask); errors++; end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  sched_scoreboard sb = new();
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit snk_hold = 0;
  int wdog = 0;
  int ops_sent = 0;

  bitmap_priority_ready_queue dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_res(sched_res_t'({out_tdata[1:0], out_tdata[2], out_tdata[8:3],
                                 out_tdata[13:9], out_tdata[45:14]}));
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WDOG_LIMIT) begin
      $display("bitmap_priority_ready_queue: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= !snk_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_op(logic [KIND_W-1:0] k, logic [TASK_W-1:0] t,
                         logic [PRIO_W-1:0] p, logic h);
    @(posedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b0, h, p, t, k};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(k, t, p, h);
    ops_sent++;
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_idle(logic [TASK_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= {2'b0, v};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.idle_id = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_ops(int n);
    logic [KIND_W-1:0] k;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = r < 50 ? KIND_ENQ : r < 90 ? KIND_REM : r < 96 ? KIND_QRY : KIND_ODD;
      send_op(k, TASK_W'($urandom_range(r < 70 ? 15 : 63)),
              PRIO_W'($urandom_range(($urandom_range(1)) ? 3 : 31)),
              1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_op(KIND_QRY, 0, 0, 0);
    send_op(KIND_REM, 5, 0, 0);
    send_op(KIND_ENQ, 63, 31, 0);
    send_op(KIND_ENQ, 0, 0, 1);
    send_op(KIND_ENQ, 0, 3, 0);
    send_op(KIND_ENQ, 1, 0, 0);
    send_op(KIND_ENQ, 2, 0, 1);
    send_op(KIND_ENQ, 3, 0, 0);
    send_op(KIND_REM, 1, 0, 0);
    send_op(KIND_REM, 2, 0, 0);
    send_op(KIND_REM, 3, 0, 0);
    send_op(KIND_REM, 0, 0, 0);
    send_op(KIND_ODD, 42, 21, 1);
    send_op(KIND_REM, 63, 0, 0);
    write_idle(6'd63);
    send_op(KIND_QRY, 0, 0, 0);
    write_idle(6'd21);
    src_idle_pct = 22; snk_idle_pct = 69;
    random_ops(300);
    write_idle(6'd0);
    src_idle_pct = 69; snk_idle_pct = 22;
    random_ops(300);
    drain();
    snk_hold = 1;
    fork
      begin repeat (200) @(posedge clk); snk_hold = 0; end
      random_ops(20);
    join
    write_idle(6'd42);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_ops(400);
    drain();
    $display("ran %0d queue operations, %0d results checked, idle id rewritten",
             ops_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("bitmap_priority_ready_queue: match");
    else
      $display("bitmap_priority_ready_queue: mismatch");
    $finish;
  end
endmodule

// File: filelist.f
hdl/bprq_pkg.sv
hdl/bprq_ctrl.sv
hdl/bprq_dp.sv
hdl/bitmap_priority_ready_queue.sv
tb/tb_bitmap_priority_ready_queue.sv
